@@ rtl/core/swrl_pkg.sv @@
// Shared constants and types for the sliding window rate limiter.
`timescale 1ns / 1ps

package swrl_pkg;

  // Default sizes of the timestamp and the pass counters
  localparam int TIME_WIDTH_DEFAULT  = 48;
  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int MAX_TIME_WIDTH      = 64;

  // Register widths
  localparam int WIN_SEC_WIDTH   = 16;
  localparam int LIMIT_WIDTH     = 32;
  localparam int ORIGIN_WIDTH    = 48;
  localparam int CFG_DATA_WIDTH  = 48;
  localparam int CFG_INDEX_WIDTH = 2;

  // Window length in ms: 16-bit seconds times 1000 fits in 26 bits
  localparam int MS_PER_SECOND  = 1000;
  localparam int WIN_MS_WIDTH   = 26;
  // Divisor holds 2*W for the weight divide
  localparam int DIVISOR_WIDTH  = WIN_MS_WIDTH + 1;
  // Weight numerator 2*c*rem + W needs COUNT_WIDTH + this many bits
  localparam int WEIGHT_EXTRA   = WIN_MS_WIDTH + 2;
  // W >= 1000 > 2^9, so the window index needs 9 bits fewer than time
  localparam int QUOT_DROP      = 9;
  localparam int DIV_WIDTH_DEFAULT = COUNT_WIDTH_DEFAULT + WEIGHT_EXTRA;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_SECONDS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REQUEST_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIME_ORIGIN    = 2'd2;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/core/swrl_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module swrl_divider #(
  parameter int DIVIDEND_W = swrl_pkg::DIV_WIDTH_DEFAULT,
  parameter int DIVISOR_W  = swrl_pkg::DIVISOR_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DIVIDEND_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0]    divisor,
  output logic [DIVIDEND_W-1:0]   quotient,
  output logic [DIVISOR_W-1:0]    remainder,
  output swrl_pkg::div_status_t   status
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], ge};
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ rtl/core/sliding_window_rate_limiter.sv @@
// Top level of the sliding window counter rate limiter.
`timescale 1ns / 1ps

// Sliding window counter rate limiter. Each input transfer is one request
// with a millisecond timestamp; each output transfer is one pass/reject
// verdict, in order. Time is cut into fixed windows of window_seconds*1000
// ms starting at time_origin. Pass counts of the current and previous
// window are kept; the previous count is weighted by the share of its
// window still inside the sliding window (rounded half up) and subtracted
// from request_limit. A request passes, and is counted, when the current
// count stays below the adjusted limit. One serial divider does both
// divides: first offset / W for the window index and remainder, then
// (2*c*rem + W) / (2*W) for the weight, both DIV_WIDTH bits wide, with
// DIV_WIDTH = max(TIME_WIDTH, COUNT_WIDTH + 28). A request occupies the
// block from accept until its verdict is loaded; in_ready is low
// meanwhile. The verdict sits in an output register, so the next request
// is taken while it waits. Configuration writes land at once and must
// only be made while the block is idle.
// A window_seconds of 0 acts as 1, a timestamp before the origin as the
// origin itself, and request_limit saturates at the counter width.

module sliding_window_rate_limiter #(
  parameter int TIME_WIDTH  = swrl_pkg::TIME_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = swrl_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [swrl_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [swrl_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [TIME_WIDTH-1:0]                 now_ms,
  // verdict channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  allowed
);

  localparam int WMS  = swrl_pkg::WIN_MS_WIDTH;
  localparam int DSRW = swrl_pkg::DIVISOR_WIDTH;
  localparam int NUMW = COUNT_WIDTH + swrl_pkg::WEIGHT_EXTRA;
  localparam int DIV_WIDTH = (TIME_WIDTH > NUMW) ? TIME_WIDTH : NUMW;
  localparam int QUOT_WIDTH = TIME_WIDTH - swrl_pkg::QUOT_DROP;
  localparam int PROD_WIDTH = COUNT_WIDTH + WMS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV1   = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV2   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // Configuration registers
  logic [swrl_pkg::WIN_SEC_WIDTH-1:0] window_seconds;
  logic [swrl_pkg::LIMIT_WIDTH-1:0]   request_limit;
  logic [swrl_pkg::ORIGIN_WIDTH-1:0]  time_origin;

  // Limiter state
  logic                   has_history;
  logic [QUOT_WIDTH-1:0]  prior_window_index;
  logic [COUNT_WIDTH-1:0] current_passes;
  logic [COUNT_WIDTH-1:0] previous_passes;

  // Sequencer and per-request working registers
  state_t                 state;
  state_t                 state_next;
  logic [WMS-1:0]         win_ms;
  logic [WMS-1:0]         rem_ms;
  logic [PROD_WIDTH-1:0]  prod;

  // Shared divider
  logic                   div_start;
  logic [DIV_WIDTH-1:0]   div_dividend;
  logic [DSRW-1:0]        div_divisor;
  logic [DIV_WIDTH-1:0]   div_quotient;
  logic [DSRW-1:0]        div_remainder;
  swrl_pkg::div_status_t  div_stat;

  logic                   accept;
  logic                   out_free;
  logic [swrl_pkg::WIN_SEC_WIDTH-1:0] win_sec;
  logic [WMS-1:0]         win_ms_comb;
  logic [swrl_pkg::MAX_TIME_WIDTH-1:0] origin_ext;
  logic [TIME_WIDTH-1:0]  origin_tw;
  logic [TIME_WIDTH-1:0]  offset;
  logic [QUOT_WIDTH-1:0]  idx;
  logic [QUOT_WIDTH:0]    prior_plus1;
  logic [COUNT_WIDTH-1:0] weight;
  logic [COUNT_WIDTH-1:0] limit_sat;
  logic [swrl_pkg::LIMIT_WIDTH:0] limit_ext;
  logic                   pass;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= swrl_pkg::WIN_SEC_WIDTH'(1);
      request_limit  <= '0;
      time_origin    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swrl_pkg::REG_WINDOW_SECONDS:
          window_seconds <= cfg_data[swrl_pkg::WIN_SEC_WIDTH-1:0];
        swrl_pkg::REG_REQUEST_LIMIT:
          request_limit <= cfg_data[swrl_pkg::LIMIT_WIDTH-1:0];
        swrl_pkg::REG_TIME_ORIGIN:
          time_origin <= cfg_data[swrl_pkg::ORIGIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Front end: window length and offset from origin, formed at accept
  // ---------------------------------------------------------------------
  assign win_sec     = (window_seconds == '0) ? swrl_pkg::WIN_SEC_WIDTH'(1) : window_seconds;
  assign win_ms_comb = WMS'(win_sec) * WMS'(swrl_pkg::MS_PER_SECOND);
  assign origin_ext  = swrl_pkg::MAX_TIME_WIDTH'(time_origin);
  assign origin_tw   = origin_ext[TIME_WIDTH-1:0];
  assign offset      = (now_ms >= origin_tw) ? (now_ms - origin_tw) : '0;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // c * rem for the weight; previous_passes and rem_ms settle as S_MUL starts
  assign prod = PROD_WIDTH'(previous_passes) * PROD_WIDTH'(rem_ms);

  // Divider operands: window divide on accept, weight divide from S_MUL
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_WIDTH'(offset);
    div_divisor  = DSRW'(win_ms_comb);
    if (accept) begin
      div_start = 1'b1;
    end else if (state == S_MUL) begin
      div_start    = 1'b1;
      div_dividend = DIV_WIDTH'({prod, 1'b0}) + DIV_WIDTH'(win_ms);
      div_divisor  = {win_ms, 1'b0};
    end
  end

  swrl_divider #(
    .DIVIDEND_W (DIV_WIDTH),
    .DIVISOR_W  (DSRW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .status    (div_stat)
  );

  // Window index out of the first divide, weight out of the second
  assign idx         = div_quotient[QUOT_WIDTH-1:0];
  assign prior_plus1 = {1'b0, prior_window_index} + (QUOT_WIDTH+1)'(1);
  // weight <= previous count, so the low bits hold all of it
  assign weight      = div_quotient[COUNT_WIDTH-1:0];

  // Limit clipped to the counter range
  assign limit_ext = {1'b0, request_limit} >> COUNT_WIDTH;
  assign limit_sat = (limit_ext != '0) ? '1 : COUNT_WIDTH'(request_limit);

  // current < limit - weight, with a weight above the limit rejecting
  assign pass = ({1'b0, current_passes} + {1'b0, weight}) < {1'b0, limit_sat};

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept)           state_next = S_DIV1;
      S_DIV1: if (div_stat.done)    state_next = S_MUL;
      S_MUL:                        state_next = S_DIV2;
      S_DIV2: if (div_stat.done)    state_next = S_DONE;
      S_DONE: if (out_free)         state_next = S_IDLE;
      default:                      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      has_history        <= 1'b0;
      prior_window_index <= '0;
      current_passes     <= '0;
      previous_passes    <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;

      // Rollover once the window index is known
      if (state == S_DIV1 && div_stat.done) begin
        if (has_history && idx != prior_window_index) begin
          if ({1'b0, idx} == prior_plus1) begin
            previous_passes <= current_passes;
          end else begin
            previous_passes <= '0;
          end
          current_passes <= '0;
        end
        has_history        <= 1'b1;
        prior_window_index <= idx;
      end

      // Verdict into the output register; count the pass
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        if (pass) begin
          current_passes <= current_passes + COUNT_WIDTH'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      win_ms <= win_ms_comb;
    end
    if (state == S_DIV1 && div_stat.done) begin
      // time left in the window: W - 1 - (offset mod W)
      rem_ms <= win_ms - WMS'(1) - div_remainder[WMS-1:0];
    end
    if (state == S_DONE && out_free) begin
      allowed <= pass;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A request is only taken while the divider is free
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("request accepted while divider busy");

  // Every accepted request starts the window divide
  assert property (@(posedge clk) disable iff (rst)
    accept |=> div_stat.busy)
    else $error("window divide did not start");

  // A verdict leaving S_DONE is loaded with the computed decision
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && allowed == $past(pass)))
    else $error("verdict not loaded");

endmodule
